FILE: hw/rtl/i8080_alu_assert.svh
// ----------------------------------------------------------------------------
// i8080_alu_assert
// Assertion macros shared by the ALU RTL.
// ----------------------------------------------------------------------------
// Each macro expects a clock named clk and an active-low reset named rst_n
// in the scope where it is used.
`ifndef I8080_ALU_ASSERT_SVH
`define I8080_ALU_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/i8080_alu_pkg.sv
// ----------------------------------------------------------------------------
// i8080_alu_pkg
// Function codes, constants and flag types for the 8080-style ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i8080_alu_pkg;

  localparam int unsigned FuncW = 5;
  localparam int unsigned DataW = 8;

  typedef logic [FuncW-1:0] func_t;
  typedef logic [DataW-1:0] data_t;

  localparam func_t FN_ADD = 5'd0;
  localparam func_t FN_ADC = 5'd1;
  localparam func_t FN_SUB = 5'd2;
  localparam func_t FN_SBB = 5'd3;
  localparam func_t FN_ANA = 5'd4;
  localparam func_t FN_XRA = 5'd5;
  localparam func_t FN_ORA = 5'd6;
  localparam func_t FN_CMP = 5'd7;
  localparam func_t FN_INR = 5'd8;
  localparam func_t FN_DCR = 5'd9;
  localparam func_t FN_RLC = 5'd10;
  localparam func_t FN_RRC = 5'd11;
  localparam func_t FN_RAL = 5'd12;
  localparam func_t FN_RAR = 5'd13;
  localparam func_t FN_DAA = 5'd14;
  localparam func_t FN_CMA = 5'd15;
  localparam func_t FN_STC = 5'd16;
  localparam func_t FN_CMC = 5'd17;

  localparam logic [3:0] BCD_MAX_DIGIT = 4'h9;
  localparam data_t      BCD_MAX_BYTE  = 8'h99;
  localparam logic [3:0] BCD_CORR      = 4'h6;
  localparam logic [3:0] NIBBLE_ONES   = 4'hf;

  typedef struct packed {
    logic sign;
    logic zero;
    logic parity;
    logic carry;
    logic aux_carry;
  } flags_t;

endpackage

FILE: hw/rtl/i8080_alu.sv
// ----------------------------------------------------------------------------
// i8080_alu
// 8080-style ALU: one arithmetic, logic, rotate or flag operation per beat.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_ready   | func, acc, operand, five flags
// out_    | output    | out_valid/out_ready | result, five flags
//
// Each beat passes an input register and then a result register, and out_valid
// rises once the beat is held in the result register; one beat per cycle is
// sustained while out_ready stays high.
// The flag and adder logic between the two registers sets the clock period.
// A stalled output holds its beat while the input register takes one more.
// Synchronous active-low reset empties both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i8080_alu_assert.svh"

module i8080_alu
  import i8080_alu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] in_func,
  input  logic [7:0] in_acc,
  input  logic [7:0] in_operand,
  input  logic       in_carry_in,
  input  logic       in_aux_carry_in,
  input  logic       in_sign_in,
  input  logic       in_zero_in,
  input  logic       in_parity_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_result,
  output logic       out_sign,
  output logic       out_zero,
  output logic       out_parity,
  output logic       out_carry,
  output logic       out_aux_carry
);

  logic   s1_valid_r, s1_valid_nxt;
  func_t  s1_func_r;
  data_t  s1_acc_r;
  data_t  s1_opd_r;
  flags_t s1_flags_r;

  logic   s2_valid_r, s2_valid_nxt;
  data_t  s2_result_r;
  flags_t s2_flags_r;

  logic   s2_free;
  logic   s1_adv;
  logic   in_take;

  data_t  res;
  flags_t flg;

  data_t      add_b;
  logic       add_cin;
  logic [8:0] add_sum;
  logic [4:0] add_low;
  logic       sub_op;
  data_t      daa_corr;
  logic [4:0] daa_low;
  data_t      szp_val;
  logic       szp_en;

  assign s2_free  = !s2_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;
  assign in_take  = in_valid && in_ready;

  // Shared adder for add, adc, sub, sbb and cmp.
  always_comb begin
    sub_op  = (s1_func_r == FN_SUB) || (s1_func_r == FN_SBB) ||
              (s1_func_r == FN_CMP);
    add_b   = sub_op ? ~s1_opd_r : s1_opd_r;
    if (s1_func_r == FN_ADC) begin
      add_cin = s1_flags_r.carry;
    end else if (s1_func_r == FN_SBB) begin
      add_cin = !s1_flags_r.carry;
    end else begin
      add_cin = sub_op;
    end
    add_sum = {1'b0, s1_acc_r} + {1'b0, add_b} + {8'd0, add_cin};
    add_low = {1'b0, s1_acc_r[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};
  end

  // Decimal adjust correction: six in each nibble that left the BCD range.
  always_comb begin
    daa_corr = '0;
    if (s1_flags_r.aux_carry || (s1_acc_r[3:0] > BCD_MAX_DIGIT)) begin
      daa_corr[3:0] = BCD_CORR;
    end
    if (s1_flags_r.carry || (s1_acc_r > BCD_MAX_BYTE)) begin
      daa_corr[7:4] = BCD_CORR;
    end
    daa_low = {1'b0, s1_acc_r[3:0]} + {1'b0, daa_corr[3:0]};
  end

  always_comb begin
    res    = s1_acc_r;
    flg    = s1_flags_r;
    szp_en = 1'b0;
    unique case (s1_func_r)
      FN_ADD, FN_ADC: begin
        res           = add_sum[7:0];
        flg.carry     = add_sum[8];
        flg.aux_carry = add_low[4];
        szp_en        = 1'b1;
      end
      FN_SUB, FN_SBB, FN_CMP: begin
        // Carry out of the complement add means no borrow.
        res           = (s1_func_r == FN_CMP) ? s1_acc_r : add_sum[7:0];
        flg.carry     = !add_sum[8];
        flg.aux_carry = add_low[4];
        szp_en        = 1'b1;
      end
      FN_ANA: begin
        res           = s1_acc_r & s1_opd_r;
        flg.carry     = 1'b0;
        flg.aux_carry = s1_acc_r[3] | s1_opd_r[3];
        szp_en        = 1'b1;
      end
      FN_XRA: begin
        res           = s1_acc_r ^ s1_opd_r;
        flg.carry     = 1'b0;
        flg.aux_carry = 1'b0;
        szp_en        = 1'b1;
      end
      FN_ORA: begin
        res           = s1_acc_r | s1_opd_r;
        flg.carry     = 1'b0;
        flg.aux_carry = 1'b0;
        szp_en        = 1'b1;
      end
      FN_INR: begin
        res           = s1_opd_r + 8'd1;
        flg.aux_carry = (s1_opd_r[3:0] == NIBBLE_ONES);
        szp_en        = 1'b1;
      end
      FN_DCR: begin
        res           = s1_opd_r - 8'd1;
        flg.aux_carry = (s1_opd_r[3:0] != 4'd0);
        szp_en        = 1'b1;
      end
      FN_RLC: begin
        res       = {s1_acc_r[6:0], s1_acc_r[7]};
        flg.carry = s1_acc_r[7];
      end
      FN_RRC: begin
        res       = {s1_acc_r[0], s1_acc_r[7:1]};
        flg.carry = s1_acc_r[0];
      end
      FN_RAL: begin
        res       = {s1_acc_r[6:0], s1_flags_r.carry};
        flg.carry = s1_acc_r[7];
      end
      FN_RAR: begin
        res       = {s1_flags_r.carry, s1_acc_r[7:1]};
        flg.carry = s1_acc_r[0];
      end
      FN_DAA: begin
        res           = s1_acc_r + daa_corr;
        flg.carry     = s1_flags_r.carry | (daa_corr[7:4] != 4'd0);
        flg.aux_carry = daa_low[4];
        szp_en        = 1'b1;
      end
      FN_CMA: begin
        res = ~s1_acc_r;
      end
      FN_STC: begin
        flg.carry = 1'b1;
      end
      FN_CMC: begin
        flg.carry = !s1_flags_r.carry;
      end
      default: begin
        // Unused codes pass the accumulator and flags through.
      end
    endcase

    // Compare sets sign, zero and parity from the difference, not the result.
    szp_val = (s1_func_r == FN_CMP) ? add_sum[7:0] : res;
    if (szp_en) begin
      flg.sign   = szp_val[7];
      flg.zero   = (szp_val == '0);
      flg.parity = ~^szp_val;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (s1_adv) begin
      s2_valid_nxt = 1'b1;
    end else if (out_ready) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r  <= in_func;
      s1_acc_r   <= in_acc;
      s1_opd_r   <= in_operand;
      s1_flags_r <= '{sign: in_sign_in, zero: in_zero_in, parity: in_parity_in,
                      carry: in_carry_in, aux_carry: in_aux_carry_in};
    end
    if (s1_adv) begin
      s2_result_r <= res;
      s2_flags_r  <= flg;
    end
  end

  assign out_valid     = s2_valid_r;
  assign out_result    = s2_result_r;
  assign out_sign      = s2_flags_r.sign;
  assign out_zero      = s2_flags_r.zero;
  assign out_parity    = s2_flags_r.parity;
  assign out_carry     = s2_flags_r.carry;
  assign out_aux_carry = s2_flags_r.aux_carry;

  `ALU_ASSERT_NEXT(a_adv_fills_out, s1_adv, s2_valid_r, "result register not loaded")
  `ALU_ASSERT_NEXT(a_stall_holds_s1, s1_valid_r && !s2_free,
                   s1_valid_r && $stable(s1_acc_r) && $stable(s1_func_r),
                   "input register lost a stalled beat")
  `ALU_ASSERT_SAME(a_ready_only_full, !in_ready,
                   s1_valid_r && s2_valid_r && !out_ready,
                   "input stalled while the pipeline could move")
  `ALU_ASSERT_NEXT(a_cmp_keeps_acc, s1_adv && (s1_func_r == FN_CMP),
                   out_result == $past(s1_acc_r), "compare changed the accumulator")
  `ALU_ASSERT_NEXT(a_add_szp, s1_adv && (s1_func_r == FN_ADD),
                   (out_sign == out_result[7]) && (out_zero == (out_result == 8'd0)),
                   "add flags do not describe the result")

endmodule
